// ----- hdl/elsc_pkg.sv -----
// Shared constants, types and a helper function for the entry line slash checker.
package elsc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CmdCntW = 3;
  localparam int unsigned SlashCntW = 3;

  localparam logic [ByteW-1:0] ChNewline = 8'h0A;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChSlash = 8'h2F;
  localparam logic [ByteW-1:0] ChPlus = 8'h2B;

  localparam logic [CmdCntW-1:0] CmdLen = 3'd5;
  localparam logic [SlashCntW-1:0] SlashGood = 3'd5;
  localparam logic [SlashCntW-1:0] SlashThird = 3'd3;
  localparam logic [SlashCntW-1:0] SlashSat = 3'd6;

  localparam logic CheckEnabledRst = 1'b0;

  typedef enum logic [2:0] {
    PH_CMD  = 3'b001,
    PH_ARG  = 3'b010,
    PH_SKIP = 3'b100
  } phase_e;

  typedef struct packed {
    logic             step;
    logic [ByteW-1:0] byte_value;
    logic             last_byte;
  } trk_req_t;

  function automatic logic [ByteW-1:0] entry_char(input logic [CmdCntW-1:0] idx);
    logic [ByteW-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h45;
      3'd1:    ch = 8'h6E;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h72;
      3'd4:    ch = 8'h79;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- hdl/elsc_line_tracker.sv -----
// Per-line command and argument state, with the per-payload alert flag.
module elsc_line_tracker
  import elsc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  trk_req_t req_i,
  output logic     alert_o
);

  phase_e               phase_q, phase_d;
  logic [CmdCntW-1:0]   cmd_cnt_q, cmd_cnt_d;
  logic                 cmd_mism_q, cmd_mism_d;
  logic [SlashCntW-1:0] slash_cnt_q, slash_cnt_d;
  logic                 ats_q, ats_d;
  logic                 bad_q, bad_d;
  logic                 alert_q, alert_d;

  always_comb begin
    phase_d     = phase_q;
    cmd_cnt_d   = cmd_cnt_q;
    cmd_mism_d  = cmd_mism_q;
    slash_cnt_d = slash_cnt_q;
    ats_d       = ats_q;
    bad_d       = bad_q;
    alert_d     = alert_q;
    if (req_i.byte_value == ChNewline) begin
      if (!req_i.last_byte && phase_q == PH_ARG && (bad_q || slash_cnt_q != SlashGood)) begin
        alert_d = 1'b1;
      end
      phase_d     = PH_CMD;
      cmd_cnt_d   = '0;
      cmd_mism_d  = 1'b0;
      slash_cnt_d = '0;
      ats_d       = 1'b0;
      bad_d       = 1'b0;
    end else begin
      case (phase_q)
        PH_CMD: begin
          if (req_i.byte_value == ChSpace) begin
            phase_d = (!cmd_mism_q && cmd_cnt_q == CmdLen) ? PH_ARG : PH_SKIP;
          end else if (cmd_cnt_q < CmdLen && req_i.byte_value == entry_char(cmd_cnt_q)) begin
            cmd_cnt_d = cmd_cnt_q + 3'd1;
          end else begin
            cmd_mism_d = 1'b1;
          end
        end
        PH_ARG: begin
          if (ats_q) begin
            if (req_i.byte_value != ChSlash && req_i.byte_value != ChPlus) begin
              bad_d = 1'b1;
            end
            ats_d = 1'b0;
          end
          if (req_i.byte_value == ChSlash) begin
            if (slash_cnt_q < SlashSat) begin
              slash_cnt_d = slash_cnt_q + 3'd1;
            end
            if (slash_cnt_d == SlashThird) begin
              ats_d = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign alert_o = alert_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CMD;
      cmd_cnt_q   <= '0;
      cmd_mism_q  <= 1'b0;
      slash_cnt_q <= '0;
      ats_q       <= 1'b0;
      bad_q       <= 1'b0;
      alert_q     <= 1'b0;
    end else if (req_i.step) begin
      if (req_i.last_byte) begin
        phase_q     <= PH_CMD;
        cmd_cnt_q   <= '0;
        cmd_mism_q  <= 1'b0;
        slash_cnt_q <= '0;
        ats_q       <= 1'b0;
        bad_q       <= 1'b0;
        alert_q     <= 1'b0;
      end else begin
        phase_q     <= phase_d;
        cmd_cnt_q   <= cmd_cnt_d;
        cmd_mism_q  <= cmd_mism_d;
        slash_cnt_q <= slash_cnt_d;
        ats_q       <= ats_d;
        bad_q       <= bad_d;
        alert_q     <= alert_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_slash_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slash_cnt_q <= SlashSat)
    else $error("Slash count went past its saturation value.");

  a_cmd_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_cnt_q <= CmdLen)
    else $error("Command match count went past the command length.");

  a_ats_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ats_q |-> (slash_cnt_q == SlashThird && phase_q == PH_ARG))
    else $error("Third-slash flag set outside the third slash of an argument.");

  a_payload_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.step && req_i.last_byte) |=> (phase_q == PH_CMD && !alert_q && slash_cnt_q == '0))
    else $error("State not cleared after the last byte of a payload.");
`endif

endmodule

// ----- hdl/entry_line_slash_checker_unit.sv -----
// Top level of the entry line slash checker: input stage, line tracker and result register.
//
//   channel   direction  signals                                   transfer
//   in        sink       in_valid_i/in_ready_o, byte_value_i,      one payload byte
//                        last_byte_i
//   out       source     out_valid_o/out_ready_i, match_o           one match bit per payload when enabled
//   cfg       sink       cfg_valid_i/cfg_ready_o, cfg_data_i        check_enabled register
//
// A byte is taken every cycle unless a stalled result holds the input stage; a payload's result
// passes the input register and then the result register. The rate is set by the input register.
// Reset clears all line and payload state and disables checking.
// A stalled result holds the input stage only when that stage holds a last byte and checking is enabled.
module entry_line_slash_checker_unit
  import elsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] byte_value_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             match_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i
);

  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;
  logic             check_en_q;
  logic             out_valid_q;
  logic             match_q;
  logic             produce;
  logic             out_free;
  logic             proc;
  logic             alert;
  trk_req_t         trk_req;

  assign produce    = s1_last_q && check_en_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign proc       = s1_valid_q && (!produce || out_free);
  assign in_ready_o = !s1_valid_q || proc;

  assign trk_req.step       = proc;
  assign trk_req.byte_value = s1_byte_q;
  assign trk_req.last_byte  = s1_last_q;

  elsc_line_tracker u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (trk_req),
    .alert_o (alert)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= byte_value_i;
      s1_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && produce) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && produce) begin
      match_q <= alert;
    end
  end

  assign cfg_ready_o = !s1_valid_q && !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_en_q <= CheckEnabledRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      check_en_q <= cfg_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign match_o     = match_q;

`ifndef SYNTHESIS
  a_result_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q && check_en_q))
    else $error("Result raised without a last byte under enabled checking.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(proc && produce))
    else $error("Pending result overwritten.");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> (!s1_valid_q && !out_valid_q))
    else $error("Configuration write taken while an item is in flight.");
`endif

endmodule

// ----- verif/entry_line_slash_checker_unit_test.sv -----
// Self-checking testbench for the entry line slash checker with a line-state predictor.
`timescale 1ns / 1ps

module entry_line_slash_checker_unit_test;
  import elsc_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             last;
  } payload_byte_t;

  localparam logic [39:0] CmdWord = "Entry";

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] byte_value_i = '0;
  logic             last_byte_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             match_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_data_i = 1'b0;

  entry_line_slash_checker_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .match_o      (match_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  payload_byte_t    byte_backlog[$];
  logic [ByteW-1:0] payload_buf[$];
  logic             match_due[$];

  phase_e               line_state = PH_CMD;
  logic [CmdCntW-1:0]   cmd_hits = '0;
  logic                 cmd_off = 1'b0;
  logic [SlashCntW-1:0] slashes = '0;
  logic                 past_third = 1'b0;
  logic                 arg_bad = 1'b0;
  logic                 alert = 1'b0;
  logic                 check_on = CheckEnabledRst;

  int  bytes_queued = 0;
  int  bytes_taken = 0;
  int  payloads_sent = 0;
  int  results_seen = 0;
  int  results_set = 0;
  int  cfg_writes = 0;
  int  mismatches = 0;
  int  send_gap = 0;
  int  sink_hold = 0;
  bit  calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_line_state();
    line_state = PH_CMD;
    cmd_hits = '0;
    cmd_off = 1'b0;
    slashes = '0;
    past_third = 1'b0;
    arg_bad = 1'b0;
  endfunction

  function automatic void track_line_byte(input logic [ByteW-1:0] b, input logic last);
    if (b == ChNewline) begin
      if (!last && line_state == PH_ARG && (arg_bad || slashes != SlashGood)) begin
        alert = 1'b1;
      end
      clear_line_state();
    end else if (line_state == PH_CMD) begin
      if (b == ChSpace) begin
        line_state = (!cmd_off && cmd_hits == CmdLen) ? PH_ARG : PH_SKIP;
      end else if (cmd_hits < CmdLen && b == CmdWord[8*(4-cmd_hits) +: 8]) begin
        cmd_hits++;
      end else begin
        cmd_off = 1'b1;
      end
    end else if (line_state == PH_ARG) begin
      if (past_third) begin
        if (b != ChSlash && b != ChPlus) arg_bad = 1'b1;
        past_third = 1'b0;
      end
      if (b == ChSlash) begin
        if (slashes < SlashSat) slashes++;
        if (slashes == SlashThird) past_third = 1'b1;
      end
    end
    if (last) begin
      if (check_on) match_due.push_back(alert);
      clear_line_state();
      alert = 1'b0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    payload_byte_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      byte_value_i <= '0;
      last_byte_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        track_line_byte(byte_value_i, last_byte_i);
        bytes_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
          send_gap = $urandom_range(1, 16);
        end
        if (send_gap == 0 && byte_backlog.size() > 0) begin
          nxt = byte_backlog.pop_front();
          in_valid_i <= 1'b1;
          byte_value_i <= nxt.value;
          last_byte_i <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (match_o === 1'b1) results_set++;
        if (match_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("MISMATCH: match %b with no result pending", match_o);
        end else begin
          want = match_due.pop_front();
          if (match_o !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("MISMATCH: result %0d expected match %b, got %b",
                       results_seen, want, match_o);
            end
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        sink_hold = $urandom_range(1, 16);
      end
      out_ready_i <= (sink_hold == 0);
    end
  end

  task automatic write_check_enable(input logic value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    check_on = value;
    cfg_writes++;
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_queued) @(posedge clk_i);
    while (match_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) payload_buf.push_back(s[i]);
  endtask

  function automatic logic [ByteW-1:0] plain_char();
    logic [ByteW-1:0] c;
    c = ByteW'($urandom_range(32, 126));
    if (c == ChSlash) c = 8'h61;
    return c;
  endfunction

  task automatic put_filler();
    repeat ($urandom_range(0, 2)) payload_buf.push_back(plain_char());
  endtask

  task automatic put_argument();
    int target;
    int n;
    target = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(0, 7);
    n = 0;
    while (n < target) begin
      put_filler();
      payload_buf.push_back(ChSlash);
      n++;
      if (n == 3) begin
        case ($urandom_range(0, 5))
          0, 1, 2: payload_buf.push_back(ChPlus);
          3: payload_buf.push_back(plain_char());
          4: begin
            if (n < target) begin
              payload_buf.push_back(ChSlash);
              n++;
            end
          end
          default: ;
        endcase
      end
    end
    put_filler();
  endtask

  task automatic put_line();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        put_text("Entry ");
        put_argument();
      end
      6, 7: begin
        case ($urandom_range(0, 5))
          0: put_text("Entr ");
          1: put_text("Entryy ");
          2: put_text("entry ");
          3: put_text("XEntry ");
          4: put_text("Entry");
          default: put_text("EntryEntry ");
        endcase
        put_argument();
      end
      default: begin
        repeat ($urandom_range(1, 12)) payload_buf.push_back(ByteW'($urandom_range(0, 255)));
      end
    endcase
    payload_buf.push_back(ChNewline);
  endtask

  task automatic ship_payload();
    payload_byte_t item;
    foreach (payload_buf[i]) begin
      item.value = payload_buf[i];
      item.last = (i == payload_buf.size() - 1);
      byte_backlog.push_back(item);
      bytes_queued++;
    end
    payload_buf.delete();
    payloads_sent++;
  endtask

  task automatic run_phase(input logic enable, input int nbytes);
    int start;
    write_check_enable(enable);
    start = bytes_queued;
    while (bytes_queued - start < nbytes) begin
      if ($urandom_range(0, 19) == 0) begin
        payload_buf.push_back(ByteW'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) put_line();
        if ($urandom_range(0, 2) == 0) begin
          put_text("Entry ");
          put_argument();
        end
      end
      ship_payload();
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty argument with a trailing byte, a newline that ends the payload, a lone byte, and a command with no space.
    write_check_enable(1'b1);
    put_text("Entry \n");
    payload_buf.push_back(8'hFF);
    ship_payload();
    put_text("Entry \n");
    ship_payload();
    payload_buf.push_back(8'h00);
    ship_payload();
    put_text("Entry\n");
    payload_buf.push_back(8'h7F);
    ship_payload();
    wait_idle();

    run_phase(1'b1, 400);
    run_phase(1'b0, 250);
    run_phase(1'b1, 450);
    run_phase(1'b0, 250);
    calm = 1'b1;
    run_phase(1'b1, 450);

    $display("Run covered %0d bytes in %0d payloads, %0d results checked, %0d of them set.",
             bytes_taken, payloads_sent, results_seen, results_set);
    $display("Check enable was written %0d times; idle bursts ran on both channels.",
             cfg_writes);
    if (mismatches == 0 && match_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Timeout after %0d of %0d bytes", bytes_taken, bytes_queued);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/elsc_pkg.sv
hdl/elsc_line_tracker.sv
hdl/entry_line_slash_checker_unit.sv
verif/entry_line_slash_checker_unit_test.sv
